// File: rtl/code128b_symbol_encoder_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef CODE128B_SYMBOL_ENCODER_DEFINES_SVH
`define CODE128B_SYMBOL_ENCODER_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define C128B_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset.
`define C128B_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/c128b_pkg.sv
package c128b_pkg;

  localparam logic [6:0] START_B_CODE  = 7'd104;
  localparam logic [6:0] STOP_CODE     = 7'd106;
  localparam logic [6:0] NUM_PATTERNS  = 7'd106;
  localparam logic [7:0] FIRST_PRINT   = 8'd32;
  localparam logic [7:0] LAST_PRINT    = 8'd126;
  localparam logic [6:0] LAST_WEIGHT   = 7'd102;

  // Stop pattern 2331112
  localparam logic [27:0] STOP_PATTERN = 28'h2331112;

  // One nibble per element: bar, space, bar, space, bar, space.
  localparam logic [23:0] SYM_PATTERN [0:105] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
    24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
    24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
    24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
    24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
    24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
    24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
    24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
    24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
    24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
    24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
    24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
    24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
    24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
    24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
    24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
    24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
    24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
    24'h211232
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic [6:0] symbol_value;
    logic [2:0] width_a;
    logic [2:0] width_b;
    logic [2:0] width_c;
    logic [2:0] width_d;
    logic [2:0] width_e;
    logic [2:0] width_f;
    logic [1:0] width_g;
    logic       is_error;
    logic       end_of_message;
  } sym_t;

endpackage

// File: rtl/c128b_out_format.sv
module c128b_out_format (
  input  logic [6:0]      sym_value,
  input  logic            err,
  output c128b_pkg::sym_t beat
);
  import c128b_pkg::*;

  logic [6:0]  idx;
  logic [23:0] pat;

  assign idx = (sym_value < NUM_PATTERNS) ? sym_value : 7'd0;
  assign pat = SYM_PATTERN[idx];

  always_comb begin
    beat = '0;
    if (err) begin
      beat.is_error       = 1'b1;
      beat.end_of_message = 1'b1;
    end else if (sym_value == STOP_CODE) begin
      beat.symbol_value   = sym_value;
      beat.width_a        = STOP_PATTERN[26:24];
      beat.width_b        = STOP_PATTERN[22:20];
      beat.width_c        = STOP_PATTERN[18:16];
      beat.width_d        = STOP_PATTERN[14:12];
      beat.width_e        = STOP_PATTERN[10:8];
      beat.width_f        = STOP_PATTERN[6:4];
      beat.width_g        = STOP_PATTERN[1:0];
      beat.end_of_message = 1'b1;
    end else begin
      beat.symbol_value = sym_value;
      beat.width_a      = pat[22:20];
      beat.width_b      = pat[18:16];
      beat.width_c      = pat[14:12];
      beat.width_d      = pat[10:8];
      beat.width_e      = pat[6:4];
      beat.width_f      = pat[2:0];
    end
  end

endmodule

// File: rtl/code128b_symbol_encoder.sv
// An accepted beat is registered in stage 1, then in the burst register, whose head
// drives the output. Throughput: one beat per cycle for mid-message characters when
// the output does not stall; a first character adds a start symbol and a last adds
// check and stop, during which the input stalls while the burst register drains.
// Reset: synchronous, active high; clears message state, checksum and both stages.
`include "code128b_symbol_encoder_defines.svh"

module code128b_symbol_encoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  c128b_pkg::char_t char_beat,
  output logic             sym_valid,
  input  logic             sym_stall,
  output c128b_pkg::sym_t  sym_beat
);
  import c128b_pkg::*;

  // Reduce a value below 9856 modulo 103 by folding: 128 == 25 (mod 103).
  function automatic logic [6:0] mod103(input logic [13:0] x);
    logic [10:0] y;
    logic [8:0]  z;
    logic [8:0]  r;
    y = ({4'b0, x[13:7]} << 4) + ({4'b0, x[13:7]} << 3) + {4'b0, x[13:7]}
        + {4'b0, x[6:0]};
    z = ({5'b0, y[10:7]} << 4) + ({5'b0, y[10:7]} << 3) + {5'b0, y[10:7]}
        + {2'b0, y[6:0]};
    if (z >= 9'd412)      r = z - 9'd412;
    else if (z >= 9'd309) r = z - 9'd309;
    else if (z >= 9'd206) r = z - 9'd206;
    else if (z >= 9'd103) r = z - 9'd103;
    else                  r = z;
    return r[6:0];
  endfunction

  // ---------------------------------------------------------------------
  // Message tracking, done at input accept time
  // ---------------------------------------------------------------------
  logic       in_message;
  logic       dropping;
  logic [6:0] pos;        // weight of the next character, mod 103

  // Stage 1: captured character with its weighted product
  logic        s1_valid;
  logic        s1_err;
  logic        s1_start;
  logic        s1_last;
  logic [6:0]  s1_val;
  logic [13:0] s1_prod;

  // Running checksum, updated as items leave stage 1
  logic [6:0]  acc;

  // Burst register: up to four symbols queued for the output, head at [0]
  logic        b_valid;
  logic [2:0]  b_cnt;
  logic        b_err;
  logic [6:0]  b_sym [4];

  logic        char_accept;
  logic        sym_accept;
  logic        printable;
  logic        s1_load;
  logic        b_free;
  logic        s1_move;
  logic [6:0]  char_val;
  logic [13:0] sum_x;
  logic [6:0]  chk;
  logic [6:0]  acc_next;
  logic [2:0]  b_cnt_next;
  logic [6:0]  b_sym_next [4];

  assign char_accept = char_valid && !char_stall;
  assign sym_accept  = sym_valid && !sym_stall;
  assign printable   = (char_beat.char_code >= FIRST_PRINT) &&
                       (char_beat.char_code <= LAST_PRINT);
  assign s1_load     = char_accept && !dropping;
  assign char_val    = 7'(char_beat.char_code - FIRST_PRINT);

  // The burst frees when empty or when its final symbol leaves this cycle.
  assign b_free      = !b_valid || (sym_accept && (b_cnt == 3'd1));
  assign s1_move     = s1_valid && b_free;
  assign char_stall  = s1_valid && !b_free;

  // Checksum including the character in stage 1
  assign sum_x = {7'b0, acc} + s1_prod;
  assign chk   = mod103(sum_x);

  // Symbol list for the item leaving stage 1
  always_comb begin
    acc_next      = s1_last ? START_B_CODE : chk;
    b_sym_next[0] = s1_val;
    b_sym_next[1] = chk;
    b_sym_next[2] = STOP_CODE;
    b_sym_next[3] = STOP_CODE;
    b_cnt_next    = s1_last ? 3'd3 : 3'd1;
    if (s1_err) begin
      acc_next      = START_B_CODE;
      b_sym_next[0] = 7'd0;
      b_cnt_next    = 3'd1;
    end else if (s1_start) begin
      b_sym_next[0] = START_B_CODE;
      b_sym_next[1] = s1_val;
      b_sym_next[2] = chk;
      b_sym_next[3] = STOP_CODE;
      b_cnt_next    = s1_last ? 3'd4 : 3'd2;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      dropping   <= 1'b0;
      pos        <= 7'd1;
      s1_valid   <= 1'b0;
      acc        <= START_B_CODE;
      b_valid    <= 1'b0;
      b_cnt      <= 3'd0;
    end else begin
      // An aborted message swallows beats up to its last character.
      if (char_accept && dropping && char_beat.last_char) begin
        dropping <= 1'b0;
      end
      if (s1_load) begin
        if (!printable) begin
          in_message <= 1'b0;
          pos        <= 7'd1;
          dropping   <= !char_beat.last_char;
        end else begin
          in_message <= !char_beat.last_char;
          if (char_beat.last_char) begin
            pos <= 7'd1;
          end else if (pos == LAST_WEIGHT) begin
            pos <= 7'd0;
          end else begin
            pos <= pos + 7'd1;
          end
        end
      end

      // A new beat refills stage 1 in the same cycle its item moves on.
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      // A reload replaces the burst whose final symbol leaves this cycle.
      if (s1_move) begin
        b_valid <= 1'b1;
        b_cnt   <= b_cnt_next;
        acc     <= acc_next;
      end else if (sym_accept) begin
        b_cnt <= b_cnt - 3'd1;
        if (b_cnt == 3'd1) begin
          b_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_err   <= !printable;
      s1_start <= !in_message;
      s1_last  <= char_beat.last_char;
      s1_val   <= char_val;
      s1_prod  <= {7'b0, char_val} * {7'b0, pos};
    end
    if (s1_move) begin
      b_err    <= s1_err;
      b_sym[0] <= b_sym_next[0];
      b_sym[1] <= b_sym_next[1];
      b_sym[2] <= b_sym_next[2];
      b_sym[3] <= b_sym_next[3];
    end else if (sym_accept) begin
      b_sym[0] <= b_sym[1];
      b_sym[1] <= b_sym[2];
      b_sym[2] <= b_sym[3];
    end
  end

  // Head of the burst, expanded to bar and space widths
  assign sym_valid = b_valid;

  c128b_out_format u_fmt (
    .sym_value (b_sym[0]),
    .err       (b_err),
    .beat      (sym_beat)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `C128B_ASSERT_IMPLY(a_burst_nonempty, clk, rst, b_valid,
    (b_cnt != 3'd0) && (b_cnt <= 3'd4), "burst valid with bad symbol count")
  `C128B_ASSERT_IMPLY(a_acc_range, clk, rst, 1'b1,
    (acc <= 7'd102) || (acc == START_B_CODE), "checksum out of range")
  `C128B_ASSERT_IMPLY(a_err_single, clk, rst, b_valid && b_err,
    b_cnt == 3'd1, "error result queued with other symbols")
  `C128B_ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !b_free,
    s1_valid && $stable(s1_val) && $stable(s1_prod), "stage 1 item lost while blocked")

endmodule

// File: bench/code128b_symbol_encoder_tb.sv
`timescale 1ns / 1ps

module code128b_symbol_encoder_tb;
  import c128b_pkg::*;

  localparam int CHECK_MODULUS = 103;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES  = 16;    // covers stage 1 and the burst register plus a burst
  localparam int RANDOM_ITEMS  = 250;
  localparam int HOLD_AFTER    = 30;    // results seen before the long receiver hold
  localparam int HOLD_CYCLES   = 150;

  // Bar/space widths per symbol value, one nibble per element (b s b s b s).
  localparam logic [23:0] BAR_WIDTHS [0:105] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
    24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
    24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
    24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
    24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
    24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
    24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
    24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
    24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
    24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
    24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
    24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
    24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
    24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
    24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
    24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
    24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
    24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
    24'h211232
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  char_valid = 1'b0;
  logic  char_stall;
  char_t char_beat = '0;
  logic  sym_valid;
  logic  sym_stall = 1'b0;
  sym_t  sym_beat;

  code128b_symbol_encoder uut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat),
    .sym_valid  (sym_valid),
    .sym_stall  (sym_stall),
    .sym_beat   (sym_beat)
  );

  always #4 clk = ~clk;

  // Characters waiting to be offered, and symbols the encoder still owes us.
  char_t pending_chars[$];
  sym_t  expected_syms[$];

  int errors = 0;
  int cyc = 0;

  // Shadow encoder state.
  int checksum  = 104;
  int weight    = 1;
  bit in_msg    = 1'b0;
  bit discarding = 1'b0;

  // One window in four runs with no idling on either side.
  function automatic bit quiet_window();
    return ((cyc / 128) % 4) == 0;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_window() || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic int draw_stall();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_window() || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] printable_byte();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] bad_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(127, 255));
  endfunction

  task automatic add_char(input logic [7:0] code, input logic is_last);
    char_t c;
    c.char_code = code;
    c.last_char = is_last;
    pending_chars.push_back(c);
  endtask

  task automatic add_message(input int len);
    for (int i = 0; i < len; i++) add_char(printable_byte(), i == len - 1);
  endtask

  // Queue one symbol with its widths.
  task automatic emit_symbol(input int value);
    sym_t s;
    logic [23:0] p;
    s = '0;
    s.symbol_value = 7'(value);
    if (value == int'(STOP_CODE)) begin
      // stop pattern 2331112
      s.width_a = 3'd2; s.width_b = 3'd3; s.width_c = 3'd3;
      s.width_d = 3'd1; s.width_e = 3'd1; s.width_f = 3'd1;
      s.width_g = 2'd2;
      s.end_of_message = 1'b1;
    end else begin
      p = BAR_WIDTHS[value];
      s.width_a = p[22:20]; s.width_b = p[18:16]; s.width_c = p[14:12];
      s.width_d = p[10:8];  s.width_e = p[6:4];   s.width_f = p[2:0];
    end
    expected_syms.push_back(s);
  endtask

  task automatic restart_message();
    checksum = int'(START_B_CODE);
    weight   = 1;
    in_msg   = 1'b0;
  endtask

  // Work out the symbols one accepted character produces.
  task automatic encode_char(input char_t c);
    sym_t s;
    int v;
    if (discarding) begin
      // rest of an aborted message: silent until its last character
      if (c.last_char) discarding = 1'b0;
      return;
    end
    if (c.char_code < FIRST_PRINT || c.char_code > LAST_PRINT) begin
      s = '0;
      s.is_error = 1'b1;
      s.end_of_message = 1'b1;
      expected_syms.push_back(s);
      restart_message();
      discarding = !c.last_char;
      return;
    end
    if (!in_msg) begin
      emit_symbol(int'(START_B_CODE));
      in_msg = 1'b1;
    end
    v = int'(c.char_code) - int'(FIRST_PRINT);
    emit_symbol(v);
    checksum = (checksum + v * weight) % CHECK_MODULUS;
    weight   = (weight + 1) % CHECK_MODULUS;  // 102 wraps to 0
    if (c.last_char) begin
      emit_symbol(checksum);
      emit_symbol(int'(STOP_CODE));
      restart_message();
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_symbol(input sym_t want, input sym_t got);
    compare_field("symbol_value",   8'(want.symbol_value),   8'(got.symbol_value));
    compare_field("width_a",        8'(want.width_a),        8'(got.width_a));
    compare_field("width_b",        8'(want.width_b),        8'(got.width_b));
    compare_field("width_c",        8'(want.width_c),        8'(got.width_c));
    compare_field("width_d",        8'(want.width_d),        8'(got.width_d));
    compare_field("width_e",        8'(want.width_e),        8'(got.width_e));
    compare_field("width_f",        8'(want.width_f),        8'(got.width_f));
    compare_field("width_g",        8'(want.width_g),        8'(got.width_g));
    compare_field("is_error",       8'(want.is_error),       8'(got.is_error));
    compare_field("end_of_message", 8'(want.end_of_message), 8'(got.end_of_message));
  endtask

  // Character driver. A new beat is loaded only when the current one has gone
  // (or none is up), so a stalled beat holds still. Prediction happens at the
  // accepting edge, from the values the encoder actually sampled.
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      gap_left <= 0;
    end else if (!char_valid || !char_stall) begin
      if (char_valid) encode_char(char_beat);
      if (gap_left > 0) begin
        char_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_chars.size() > 0) begin
        char_beat <= pending_chars.pop_front();
        char_valid <= 1'b1;
        gap_left <= draw_gap();
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // Symbol monitor and receiver stall. After a few dozen results it holds off
  // for a long stretch so the encoder backs up and stalls its input.
  int  hold_left = 0;
  int  results_seen = 0;
  bit  pressure_done = 1'b0;
  int  n_stall;

  always @(posedge clk) begin
    if (rst) begin
      sym_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (sym_valid && !sym_stall) begin
        if (expected_syms.size() == 0) begin
          $error("symbol beat with nothing expected: %p", sym_beat);
          errors++;
        end else begin
          check_symbol(expected_syms.pop_front(), sym_beat);
        end
        results_seen++;
      end
      if (!pressure_done && results_seen >= HOLD_AFTER) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        sym_stall <= 1'b1;
        hold_left--;
      end else begin
        n_stall = draw_stall();
        sym_stall <= (n_stall > 0);
        if (n_stall > 0) hold_left = n_stall - 1;
      end
    end
  end

  // Watchdog: cycles with no beat moving on either side.
  int idle_cycles = 0;

  always @(posedge clk) begin
    cyc++;
    if (rst || (char_valid && !char_stall) || (sym_valid && !sym_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("code128b_symbol_encoder test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int counted;
    int kind;
    int len;
    // Directed: one-char message, both ends of the printable range.
    add_char("A", 1'b1);
    add_char(8'd32, 1'b0);
    add_char(8'd126, 1'b1);
    // Bad first character that is also last: one error, no discarding.
    add_char(8'd0, 1'b1);
    // Bad first character, not last: the rest of the message is dropped,
    // including another bad byte, until its last character.
    add_char(8'd255, 1'b0);
    add_char("x", 1'b0);
    add_char(8'd31, 1'b0);
    add_char("y", 1'b1);
    // Bad character mid-message, then the dropped tail.
    add_char("H", 1'b0);
    add_char("i", 1'b0);
    add_char(8'd127, 1'b0);
    add_char("z", 1'b1);
    // Bad last character mid-message: no discarding afterwards.
    add_char("Q", 1'b0);
    add_char(8'd31, 1'b1);
    add_char(8'd128, 1'b1);
    add_char("O", 1'b0);
    add_char("K", 1'b1);

    // One message long enough that the weight wraps past 102.
    add_message(110);
    counted = 110;
    while (counted < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = $urandom_range(1, 8);
        add_message(len);
        counted += len;
      end else if (kind == 7) begin
        add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        counted++;
      end else begin
        // broken message: good prefix, a bad byte, then an arbitrary tail
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) add_char(printable_byte(), 1'b0);
        add_char(bad_byte(), 1'($urandom_range(0, 1)));
        counted += len + 1;
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++)
          add_char(8'($urandom_range(0, 255)), i == len - 1);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() > 0 || char_valid || expected_syms.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("code128b_symbol_encoder test passed");
    end else begin
      $display("code128b_symbol_encoder test failed");
    end
    $finish;
  end

endmodule
